// File: rtl/wvm_pkg.sv
// ----------------------------------------------------------------------------
// wvm_pkg: shared constants, codes and types for the word virtual machine core
// Holds sizes, opcode and status codes, operand decode tables and the
// request and response structs of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package wvm_pkg;

   localparam int STACK_DEPTH = 1024;
   localparam int MEM_WORDS   = 32768;
   localparam int REG_COUNT   = 8;

   localparam int ADDR_W   = $clog2(MEM_WORDS);
   localparam int REG_W    = $clog2(REG_COUNT);
   localparam int SP_W     = $clog2(STACK_DEPTH + 1);
   localparam int SP_IDX_W = $clog2(STACK_DEPTH);
   localparam int VAL_W    = 15;
   localparam int WORD_W   = 16;

   // Opcodes.
   localparam logic [4:0] OP_HALT = 5'd0;
   localparam logic [4:0] OP_SET  = 5'd1;
   localparam logic [4:0] OP_PUSH = 5'd2;
   localparam logic [4:0] OP_POP  = 5'd3;
   localparam logic [4:0] OP_EQ   = 5'd4;
   localparam logic [4:0] OP_GT   = 5'd5;
   localparam logic [4:0] OP_JMP  = 5'd6;
   localparam logic [4:0] OP_JT   = 5'd7;
   localparam logic [4:0] OP_JF   = 5'd8;
   localparam logic [4:0] OP_ADD  = 5'd9;
   localparam logic [4:0] OP_MULT = 5'd10;
   localparam logic [4:0] OP_MOD  = 5'd11;
   localparam logic [4:0] OP_AND  = 5'd12;
   localparam logic [4:0] OP_OR   = 5'd13;
   localparam logic [4:0] OP_NOT  = 5'd14;
   localparam logic [4:0] OP_RMEM = 5'd15;
   localparam logic [4:0] OP_WMEM = 5'd16;
   localparam logic [4:0] OP_CALL = 5'd17;
   localparam logic [4:0] OP_RET  = 5'd18;
   localparam logic [4:0] OP_OUT  = 5'd19;
   localparam logic [4:0] OP_IN   = 5'd20;
   localparam logic [4:0] OP_NOOP = 5'd21;
   localparam logic [15:0] OP_LAST = 16'd21;

   // Status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_HALT     = 3'd1;
   localparam logic [2:0] ST_BAD_OP   = 3'd2;
   localparam logic [2:0] ST_BAD_REG  = 3'd3;
   localparam logic [2:0] ST_BAD_ARG  = 3'd4;
   localparam logic [2:0] ST_POP_EMPT = 3'd5;
   localparam logic [2:0] ST_STK_FULL = 3'd6;
   localparam logic [2:0] ST_MOD_ZERO = 3'd7;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EXEC = 1'b1;

   typedef struct packed {
      logic       start;
      logic [4:0] op;
   } alu_req_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] result;
   } alu_rsp_type;

   // Number of operand words that follow the opcode.
   function automatic logic [1:0] op_nargs(input logic [4:0] op);
      logic [1:0] n;
      unique case (op)
         OP_SET, OP_NOT, OP_RMEM, OP_JT, OP_JF, OP_WMEM:              n = 2'd2;
         OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR:        n = 2'd3;
         OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT, OP_IN:             n = 2'd1;
         default:                                                     n = 2'd0;
      endcase
      return n;
   endfunction

   // Bit i set when operand i names a target register rather than a value.
   function automatic logic [2:0] op_regmask(input logic [4:0] op);
      logic [2:0] m;
      unique case (op)
         OP_SET, OP_POP, OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD,
         OP_AND, OP_OR, OP_NOT, OP_RMEM, OP_IN:                       m = 3'b001;
         default:                                                     m = 3'b000;
      endcase
      return m;
   endfunction

endpackage

// File: rtl/wvm_alu.sv
// ----------------------------------------------------------------------------
// wvm_alu: shared arithmetic unit
// Compare, add, multiply and logic operations with a registered result, and
// a bit-serial restoring remainder for the modulo operation.
// ----------------------------------------------------------------------------
module wvm_alu
   import wvm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  alu_req_type      req,
   input  logic [VAL_W-1:0] a,
   input  logic [VAL_W-1:0] b,
   output alu_rsp_type      rsp
);

   logic             mod_busy_ff;
   logic [3:0]       cnt_ff;
   logic [VAL_W-1:0] rem_ff;
   logic [VAL_W-1:0] dvd_ff;
   logic [VAL_W-1:0] dsr_ff;
   logic [VAL_W-1:0] result_ff;
   logic             done_ff;

   logic [VAL_W:0]   trial;
   logic [VAL_W:0]   trial_sub;
   logic [2*VAL_W-1:0] product;
   logic [VAL_W-1:0] simple;

   assign trial     = {rem_ff, dvd_ff[VAL_W-1]};
   assign trial_sub = trial - {1'b0, dsr_ff};
   assign product   = a * b;

   always_comb begin
      unique case (req.op)
         OP_EQ:   simple = VAL_W'(a == b);
         OP_GT:   simple = VAL_W'(a > b);
         OP_ADD:  simple = a + b;
         OP_MULT: simple = product[VAL_W-1:0];
         OP_AND:  simple = a & b;
         OP_OR:   simple = a | b;
         OP_NOT:  simple = ~a;
         default: simple = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_busy_ff <= 1'b0;
         done_ff     <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start && req.op == OP_MOD) begin
            mod_busy_ff <= 1'b1;
            cnt_ff      <= 4'(VAL_W - 1);
            rem_ff      <= '0;
            dvd_ff      <= a;
            dsr_ff      <= b;
         end else if (req.start) begin
            result_ff <= simple;
            done_ff   <= 1'b1;
         end else if (mod_busy_ff) begin
            // One remainder bit per cycle, most significant dividend bit first.
            rem_ff <= trial_sub[VAL_W] ? trial[VAL_W-1:0] : trial_sub[VAL_W-1:0];
            dvd_ff <= {dvd_ff[VAL_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               mod_busy_ff <= 1'b0;
               result_ff   <= trial_sub[VAL_W] ? trial[VAL_W-1:0] : trial_sub[VAL_W-1:0];
               done_ff     <= 1'b1;
            end
         end
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

// File: rtl/word_vm_instruction_core.sv
// ----------------------------------------------------------------------------
// word_vm_instruction_core: sixteen-bit word virtual machine core
// A load word writes one program word; an execute word runs one instruction
// through a multicycle sequencer around one memory port and a shared ALU.
// ----------------------------------------------------------------------------
// A load word, or an execute word while halted, answers in the cycle after
// it is taken. An instruction reads each word (opcode and operands) through
// the fetch and word states over the one memory read port, then runs an
// execute state, then an ALU, rmem or stack read wait where needed, then a
// commit state; a bad opcode skips to commit. busy stays high throughout.
// Reset clears registers, pc, stack pointer and halt flag; memories are not
// cleared. The result strobe lasts one cycle and cannot be stalled.
module word_vm_instruction_core
   import wvm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [ADDR_W-1:0] req_load_addr,
   input  logic [WORD_W-1:0] req_load_data,
   input  logic [7:0]        req_in_char,
   output logic              rsp_strobe,
   output logic              rsp_out_valid,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_took_input,
   output logic              rsp_halted,
   output logic [2:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_next_pc
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b00000001,
      S_FETCH   = 8'b00000010,
      S_WORD    = 8'b00000100,
      S_EXEC    = 8'b00001000,
      S_ALU     = 8'b00010000,
      S_MEMWAIT = 8'b00100000,
      S_STKWAIT = 8'b01000000,
      S_FINISH  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   // Architectural state.
   logic [WORD_W-1:0] mem_ff [MEM_WORDS];
   logic [WORD_W-1:0] stk_ff [STACK_DEPTH];
   logic [VAL_W-1:0]  regs_ff [REG_COUNT];
   logic [ADDR_W-1:0] pc_ff;
   logic [SP_W-1:0]   sp_ff;
   logic              stopped_ff;

   // Per-instruction working registers.
   logic [WORD_W-1:0] mem_q_ff;
   logic [WORD_W-1:0] stk_q_ff;
   logic [ADDR_W-1:0] p_ff;
   logic [4:0]        op_ff;
   logic              op_phase_ff;
   logic [1:0]        opidx_ff;
   logic              have_a_ff;
   logic [2:0]        err_ff;
   logic [REG_W-1:0]  r_ff;
   logic [VAL_W-1:0]  a_ff;
   logic [VAL_W-1:0]  b_ff;
   logic [VAL_W-1:0]  res_ff;
   logic [7:0]        in_char_ff;
   logic              wr_ff;
   logic              ov_ff;
   logic              took_ff;

   logic              accept;
   logic              sp_empty;
   logic              sp_full;
   logic [SP_W-1:0]   sp_dec;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [WORD_W-1:0] mem_wdata;
   logic [SP_IDX_W-1:0] stk_addr;
   logic              stk_we;
   logic [WORD_W-1:0] stk_wdata;
   logic [1:0]        nargs;
   logic              last_arg;
   logic [2:0]        regmask;
   logic              cur_is_reg;
   logic              reg_ok;
   logic [VAL_W-1:0]  arg_val;
   logic              arg_ok;
   logic              is_alu_op;
   logic              stack_push;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   wvm_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .a     (a_ff),
      .b     (b_ff),
      .rsp   (alu_rsp)
   );

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign sp_empty = (sp_ff == '0);
   assign sp_full  = (sp_ff >= SP_W'(STACK_DEPTH));
   assign sp_dec   = sp_ff - SP_W'(1);
   assign nargs    = op_nargs(op_ff);
   assign last_arg = (opidx_ff == nargs - 2'd1);
   assign regmask  = op_regmask(op_ff);
   assign cur_is_reg = regmask[opidx_ff];

   // Operand decode of the word just read: a register name is 0..7 or
   // 32768..32775; a value is a literal below 32768 or one of the registers.
   assign reg_ok  = (mem_q_ff[14:3] == '0);
   assign arg_ok  = !mem_q_ff[15] || reg_ok;
   assign arg_val = mem_q_ff[15] ? (reg_ok ? regs_ff[mem_q_ff[REG_W-1:0]] : '0)
                                 : mem_q_ff[VAL_W-1:0];

   assign is_alu_op = (op_ff == OP_EQ) || (op_ff == OP_GT) || (op_ff == OP_ADD) ||
                      (op_ff == OP_MULT) || (op_ff == OP_MOD) || (op_ff == OP_AND) ||
                      (op_ff == OP_OR) || (op_ff == OP_NOT);
   assign stack_push = (op_ff == OP_PUSH) || (op_ff == OP_CALL);

   assign alu_req.start = (state_ff == S_EXEC) && is_alu_op && (err_ff == ST_OK) &&
                          !(op_ff == OP_MOD && b_ff == '0);
   assign alu_req.op    = op_ff;

   // Main memory port: loads while idle, instruction and rmem reads, wmem writes.
   always_comb begin
      mem_addr  = p_ff;
      mem_we    = 1'b0;
      mem_wdata = req_load_data;
      if (state_ff == S_IDLE) begin
         mem_addr = req_load_addr;
         mem_we   = accept && (req_cmd == CMD_LOAD);
      end else if (state_ff == S_EXEC) begin
         mem_addr  = a_ff;
         mem_we    = (op_ff == OP_WMEM) && (err_ff == ST_OK);
         mem_wdata = WORD_W'(b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_addr] <= mem_wdata;
      end
      mem_q_ff <= mem_ff[mem_addr];
   end

   // Return stack port: push writes at the pointer, pop and ret read below it.
   always_comb begin
      stk_addr  = sp_ff[SP_IDX_W-1:0];
      stk_we    = (state_ff == S_EXEC) && stack_push && (err_ff == ST_OK) && !sp_full;
      stk_wdata = (op_ff == OP_PUSH) ? WORD_W'(a_ff) : WORD_W'(p_ff);
      if (op_ff == OP_POP || op_ff == OP_RET) begin
         stk_addr = sp_dec[SP_IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_ff[stk_addr] <= stk_wdata;
      end
      stk_q_ff <= stk_ff[stk_addr];
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_cmd == CMD_EXEC && !stopped_ff) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: state_in = S_WORD;
         S_WORD: begin
            if (op_phase_ff) begin
               if (mem_q_ff > OP_LAST) begin
                  state_in = S_FINISH;
               end else if (op_nargs(mem_q_ff[4:0]) == 2'd0) begin
                  state_in = S_EXEC;
               end else begin
                  state_in = S_FETCH;
               end
            end else begin
               state_in = last_arg ? S_EXEC : S_FETCH;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            if (err_ff == ST_OK) begin
               if (alu_req.start) begin
                  state_in = S_ALU;
               end else if (op_ff == OP_RMEM) begin
                  state_in = S_MEMWAIT;
               end else if ((op_ff == OP_POP || op_ff == OP_RET) && !sp_empty) begin
                  state_in = S_STKWAIT;
               end
            end
         end
         S_ALU:     state_in = alu_rsp.done ? S_FINISH : S_ALU;
         S_MEMWAIT: state_in = S_FINISH;
         S_STKWAIT: state_in = S_FINISH;
         S_FINISH:  state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pc_ff      <= '0;
         sp_ff      <= '0;
         stopped_ff <= 1'b0;
         rsp_strobe <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               // Loads and executes while halted answer without running the sequencer.
               if (accept && (req_cmd == CMD_LOAD || stopped_ff)) begin
                  rsp_strobe     <= 1'b1;
                  rsp_out_valid  <= 1'b0;
                  rsp_out_char   <= '0;
                  rsp_took_input <= 1'b0;
                  rsp_halted     <= stopped_ff;
                  rsp_status     <= ST_OK;
                  rsp_next_pc    <= pc_ff;
               end
               p_ff        <= pc_ff;
               op_phase_ff <= 1'b1;
               opidx_ff    <= '0;
               have_a_ff   <= 1'b0;
               err_ff      <= ST_OK;
               r_ff        <= '0;
               a_ff        <= '0;
               b_ff        <= '0;
               res_ff      <= '0;
               wr_ff       <= 1'b0;
               ov_ff       <= 1'b0;
               took_ff     <= 1'b0;
               in_char_ff  <= req_in_char;
            end
            S_FETCH: p_ff <= p_ff + ADDR_W'(1);
            S_WORD: begin
               if (op_phase_ff) begin
                  op_phase_ff <= 1'b0;
                  op_ff       <= mem_q_ff[4:0];
                  if (mem_q_ff > OP_LAST) begin
                     err_ff <= ST_BAD_OP;
                  end
               end else begin
                  opidx_ff <= opidx_ff + 2'd1;
                  if (cur_is_reg) begin
                     r_ff <= mem_q_ff[REG_W-1:0];
                     if (!reg_ok && err_ff == ST_OK) begin
                        err_ff <= ST_BAD_REG;
                     end
                  end else begin
                     have_a_ff <= 1'b1;
                     if (have_a_ff) begin
                        b_ff <= arg_val;
                     end else begin
                        a_ff <= arg_val;
                     end
                     if (!arg_ok && err_ff == ST_OK) begin
                        err_ff <= ST_BAD_ARG;
                     end
                  end
               end
            end
            S_EXEC: begin
               if (op_ff == OP_HALT) begin
                  err_ff <= ST_HALT;
               end else if (err_ff == ST_OK) begin
                  priority case (1'b1)
                     (op_ff == OP_SET): begin
                        res_ff <= a_ff;
                        wr_ff  <= 1'b1;
                     end
                     stack_push: begin
                        if (sp_full) begin
                           err_ff <= ST_STK_FULL;
                        end else begin
                           sp_ff <= sp_ff + SP_W'(1);
                           if (op_ff == OP_CALL) begin
                              p_ff <= a_ff;
                           end
                        end
                     end
                     (op_ff == OP_POP): begin
                        if (sp_empty) begin
                           err_ff <= ST_POP_EMPT;
                        end
                     end
                     (op_ff == OP_RET): begin
                        if (sp_empty) begin
                           err_ff <= ST_HALT;
                        end
                     end
                     (op_ff == OP_MOD && b_ff == '0): err_ff <= ST_MOD_ZERO;
                     (op_ff == OP_JMP): p_ff <= a_ff;
                     (op_ff == OP_JT): begin
                        if (a_ff != '0) begin
                           p_ff <= b_ff;
                        end
                     end
                     (op_ff == OP_JF): begin
                        if (a_ff == '0) begin
                           p_ff <= b_ff;
                        end
                     end
                     (op_ff == OP_OUT): ov_ff <= 1'b1;
                     (op_ff == OP_IN): begin
                        res_ff  <= VAL_W'(in_char_ff);
                        wr_ff   <= 1'b1;
                        took_ff <= 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            S_ALU: begin
               if (alu_rsp.done) begin
                  res_ff <= alu_rsp.result;
                  wr_ff  <= 1'b1;
               end
            end
            S_MEMWAIT: begin
               res_ff <= mem_q_ff[VAL_W-1:0];
               wr_ff  <= 1'b1;
            end
            S_STKWAIT: begin
               sp_ff <= sp_dec;
               if (op_ff == OP_RET) begin
                  p_ff <= stk_q_ff[VAL_W-1:0];
               end else begin
                  res_ff <= stk_q_ff[VAL_W-1:0];
                  wr_ff  <= 1'b1;
               end
            end
            S_FINISH: begin
               // Commit on success; any nonzero status stops the machine in place.
               rsp_strobe <= 1'b1;
               rsp_status <= err_ff;
               if (err_ff != ST_OK) begin
                  stopped_ff     <= 1'b1;
                  rsp_halted     <= 1'b1;
                  rsp_out_valid  <= 1'b0;
                  rsp_out_char   <= '0;
                  rsp_took_input <= 1'b0;
                  rsp_next_pc    <= pc_ff;
               end else begin
                  if (wr_ff) begin
                     regs_ff[r_ff] <= res_ff;
                  end
                  pc_ff          <= p_ff;
                  rsp_halted     <= 1'b0;
                  rsp_out_valid  <= ov_ff;
                  rsp_out_char   <= ov_ff ? a_ff[7:0] : 8'd0;
                  rsp_took_input <= took_ff;
                  rsp_next_pc    <= p_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // An instruction only runs while the machine is not stopped.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !stopped_ff)
      else $error("instruction in flight while stopped");

   // The stack pointer never passes the stack depth.
   assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   // A nonzero status always reports the machine as halted.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> rsp_halted)
      else $error("fault reported without halt");

   // A fault leaves the program counter where it was.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_next_pc == pc_ff))
      else $error("program counter moved on a fault");

endmodule
